// ===== rtl/imh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pkg
// Shared constants, memory port types and field helpers for the indexed heap.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 20;

    localparam int MODE_W  = 2;
    localparam int ID_W    = 10;
    localparam int VALUE_W = 20;
    localparam int TOPK_W  = 20;
    localparam int ERR_W   = 2;

    localparam int ID_SPACE = 1 << ID_W;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W    = SLOT_W + 2;
    localparam int CMP_W    = (KEY_BITS > VALUE_W) ? KEY_BITS : VALUE_W;
    localparam int SLOT_DW  = ID_W + KEY_BITS;
    localparam int POS_DW   = SLOT_W + 1;

    // Modes
    localparam logic [MODE_W-1:0] MODE_APPEND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DECREASE = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ABSENT  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_PRESENT = 2'd3;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [SLOT_W-1:0]  addr;
        logic [SLOT_DW-1:0] wdata;
    } slot_req_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ID_W-1:0]   addr;
        logic [POS_DW-1:0] wdata;
    } pos_req_t;

    // Keep the low KEY_BITS of an input value
    function automatic logic [KEY_BITS-1:0] value_to_key(input logic [VALUE_W-1:0] v);
        logic [CMP_W-1:0] t;
        t = CMP_W'(v);
        return t[KEY_BITS-1:0];
    endfunction

    // Widen a key to the compare width
    function automatic logic [CMP_W-1:0] key_ext(input logic [KEY_BITS-1:0] k);
        return CMP_W'(k);
    endfunction

    // Fit a key to the result field
    function automatic logic [TOPK_W-1:0] key_to_field(input logic [KEY_BITS-1:0] k);
        logic [CMP_W-1:0] t;
        t = CMP_W'(k);
        return t[TOPK_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/imh_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_slot_ram
// Single-port heap slot store, one {id, key} entry per slot, registered read.
// ----------------------------------------------------------------------------
module imh_slot_ram (
    input  wire logic                         clk,
    input  wire imh_pkg::slot_req_t           req,
    output logic [imh_pkg::SLOT_DW-1:0]       rdata
);

    logic [imh_pkg::SLOT_DW-1:0] mem [imh_pkg::CAPACITY];

    // Write or read one slot per cycle
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/imh_pos_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pos_ram
// Single-port id-to-slot map, {valid, slot} per id, registered read.
// ----------------------------------------------------------------------------
module imh_pos_ram (
    input  wire logic                        clk,
    input  wire imh_pkg::pos_req_t           req,
    output logic [imh_pkg::POS_DW-1:0]       rdata
);

    logic [imh_pkg::POS_DW-1:0] mem [imh_pkg::ID_SPACE];

    // Write or read one id per cycle
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/imh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imh_ctrl
// Sequencer for append, build, delete and decrease; one shared key comparator
// drives every sift decision.
// ----------------------------------------------------------------------------
module imh_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [imh_pkg::MODE_W-1:0]    mode,
    input  wire logic [imh_pkg::ID_W-1:0]      node_id,
    input  wire logic [imh_pkg::VALUE_W-1:0]   value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [imh_pkg::ID_W-1:0]           top_id,
    output logic [imh_pkg::TOPK_W-1:0]         top_key,
    output logic [imh_pkg::COUNT_W-1:0]        entry_count,
    output logic                               is_empty,
    output logic [imh_pkg::ERR_W-1:0]          error_code,
    output imh_pkg::slot_req_t                 slot_req,
    input  wire logic [imh_pkg::SLOT_DW-1:0]   slot_rdata,
    output imh_pkg::pos_req_t                  pos_req,
    input  wire logic [imh_pkg::POS_DW-1:0]    pos_rdata
);

    localparam int SW = imh_pkg::SLOT_W;
    localparam int CW = imh_pkg::COUNT_W;
    localparam int XW = imh_pkg::IDX_W;
    localparam int KB = imh_pkg::KEY_BITS;
    localparam int IW = imh_pkg::ID_W;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_LOOK  = 5'd2;
    localparam logic [4:0] S_CHK   = 5'd3;
    localparam logic [4:0] S_LOAD  = 5'd4;
    localparam logic [4:0] S_LOADW = 5'd5;
    localparam logic [4:0] S_SDT   = 5'd6;
    localparam logic [4:0] S_SDR   = 5'd7;
    localparam logic [4:0] S_SDC1  = 5'd8;
    localparam logic [4:0] S_SDC2  = 5'd9;
    localparam logic [4:0] S_SDE   = 5'd10;
    localparam logic [4:0] S_SUT   = 5'd11;
    localparam logic [4:0] S_SUC   = 5'd12;
    localparam logic [4:0] S_SUE   = 5'd13;
    localparam logic [4:0] S_TOP   = 5'd14;
    localparam logic [4:0] S_TOPW  = 5'd15;
    localparam logic [4:0] S_RES   = 5'd16;

    localparam logic [1:0] PH_BUILD    = 2'd0;
    localparam logic [1:0] PH_DEL_DOWN = 2'd1;
    localparam logic [1:0] PH_DEL_UP   = 2'd2;
    localparam logic [1:0] PH_DEC      = 2'd3;

    logic [4:0]                     state_reg, state_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [IW-1:0]                  clr_reg, clr_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [imh_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [IW-1:0]                  id_reg, id_next;
    logic [imh_pkg::VALUE_W-1:0]    val_reg, val_next;
    logic [imh_pkg::ERR_W-1:0]      err_reg, err_next;
    logic [SW-1:0]                  start_reg, start_next;
    logic [SW-1:0]                  hole_reg, hole_next;
    logic [SW-1:0]                  child_reg, child_next;
    logic [IW-1:0]                  cur_id_reg, cur_id_next;
    logic [KB-1:0]                  cur_key_reg, cur_key_next;
    logic [IW-1:0]                  best_id_reg, best_id_next;
    logic [KB-1:0]                  best_key_reg, best_key_next;
    logic                           out_valid_reg;
    logic [IW-1:0]                  top_id_reg;
    logic [imh_pkg::TOPK_W-1:0]     top_key_reg;
    logic [CW-1:0]                  entry_count_reg;
    logic                           is_empty_reg;
    logic [imh_pkg::ERR_W-1:0]      error_code_reg;

    logic [IW-1:0]                  rd_id;
    logic [KB-1:0]                  rd_key;
    logic                           pos_valid;
    logic [SW-1:0]                  pos_slot;
    logic [imh_pkg::CMP_W-1:0]      cmp_a, cmp_b, dec_diff;
    logic                           cmp_gt;
    logic [XW-1:0]                  left_idx, right_idx, count_x;
    logic [SW-1:0]                  hole_m1;
    logic                           res_load;

    assign rd_id     = slot_rdata[imh_pkg::SLOT_DW-1:KB];
    assign rd_key    = slot_rdata[KB-1:0];
    assign pos_valid = pos_rdata[imh_pkg::POS_DW-1];
    assign pos_slot  = pos_rdata[SW-1:0];
    assign left_idx  = {1'b0, hole_reg, 1'b1};
    assign right_idx = left_idx + XW'(1);
    assign count_x   = XW'(count_reg);
    assign hole_m1   = hole_reg - SW'(1);
    assign dec_diff  = cmp_a - cmp_b;
    assign res_load  = (state_reg == S_RES) && (!out_valid_reg || out_ready);

    // Route operands to the shared comparator
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        case (state_reg)
            S_LOADW:
            begin
                cmp_a = imh_pkg::key_ext(rd_key);
                cmp_b = imh_pkg::CMP_W'(val_reg);
            end
            S_SDC1:
            begin
                cmp_a = imh_pkg::key_ext(rd_key);
                cmp_b = imh_pkg::key_ext(best_key_reg);
            end
            S_SDC2:
            begin
                cmp_a = imh_pkg::key_ext(best_key_reg);
                cmp_b = imh_pkg::key_ext(cur_key_reg);
            end
            S_SUC:
            begin
                cmp_a = imh_pkg::key_ext(cur_key_reg);
                cmp_b = imh_pkg::key_ext(rd_key);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_gt = cmp_a > cmp_b;

    // Sequence one beat through lookup, sift and root fetch
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        clr_next      = clr_reg;
        count_next    = count_reg;
        mode_next     = mode_reg;
        id_next       = id_reg;
        val_next      = val_reg;
        err_next      = err_reg;
        start_next    = start_reg;
        hole_next     = hole_reg;
        child_next    = child_reg;
        cur_id_next   = cur_id_reg;
        cur_key_next  = cur_key_reg;
        best_id_next  = best_id_reg;
        best_key_next = best_key_reg;
        slot_req      = '0;
        pos_req       = '0;
        case (state_reg)
            S_CLR:
            begin
                pos_req.en   = 1'b1;
                pos_req.we   = 1'b1;
                pos_req.addr = clr_reg;
                clr_next     = clr_reg + IW'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    id_next    = node_id;
                    val_next   = value;
                    err_next   = imh_pkg::ERR_OK;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                pos_req.en   = 1'b1;
                pos_req.addr = id_reg;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_TOP;
                case (mode_reg)
                    imh_pkg::MODE_APPEND:
                    begin
                        if (pos_valid)
                        begin
                            err_next = imh_pkg::ERR_PRESENT;
                        end
                        else if (count_reg == CW'(imh_pkg::CAPACITY))
                        begin
                            err_next = imh_pkg::ERR_FULL;
                        end
                        else
                        begin
                            slot_req.en    = 1'b1;
                            slot_req.we    = 1'b1;
                            slot_req.addr  = count_reg[SW-1:0];
                            slot_req.wdata = {id_reg, imh_pkg::value_to_key(val_reg)};
                            pos_req.en     = 1'b1;
                            pos_req.we     = 1'b1;
                            pos_req.addr   = id_reg;
                            pos_req.wdata  = {1'b1, count_reg[SW-1:0]};
                            count_next     = count_reg + CW'(1);
                        end
                    end
                    imh_pkg::MODE_BUILD:
                    begin
                        if (count_reg > CW'(1))
                        begin
                            start_next = SW'(count_reg >> 1) - SW'(1);
                            phase_next = PH_BUILD;
                            state_next = S_LOAD;
                        end
                    end
                    default:
                    begin
                        if (!pos_valid)
                        begin
                            err_next = imh_pkg::ERR_ABSENT;
                        end
                        else if (mode_reg == imh_pkg::MODE_DELETE)
                        begin
                            pos_req.en    = 1'b1;
                            pos_req.we    = 1'b1;
                            pos_req.addr  = id_reg;
                            pos_req.wdata = '0;
                            count_next    = count_reg - CW'(1);
                            start_next    = pos_slot;
                            if (CW'(pos_slot) != count_reg - CW'(1))
                            begin
                                phase_next = PH_DEL_DOWN;
                                state_next = S_LOAD;
                            end
                        end
                        else
                        begin
                            start_next = pos_slot;
                            phase_next = PH_DEC;
                            state_next = S_LOAD;
                        end
                    end
                endcase
            end
            S_LOAD:
            begin
                slot_req.en   = 1'b1;
                slot_req.addr = (phase_reg == PH_DEL_DOWN) ? count_reg[SW-1:0] : start_reg;
                state_next    = S_LOADW;
            end
            S_LOADW:
            begin
                cur_id_next  = rd_id;
                cur_key_next = rd_key;
                hole_next    = start_reg;
                if (phase_reg == PH_DEC)
                begin
                    cur_key_next = cmp_gt ? dec_diff[KB-1:0] : '0;
                end
                state_next = (phase_reg == PH_DEL_UP) ? S_SUT : S_SDT;
            end
            S_SDT:
            begin
                if (left_idx >= count_x)
                begin
                    state_next = S_SDE;
                end
                else
                begin
                    slot_req.en   = 1'b1;
                    slot_req.addr = left_idx[SW-1:0];
                    state_next    = S_SDR;
                end
            end
            S_SDR:
            begin
                best_id_next  = rd_id;
                best_key_next = rd_key;
                child_next    = left_idx[SW-1:0];
                if (right_idx < count_x)
                begin
                    slot_req.en   = 1'b1;
                    slot_req.addr = right_idx[SW-1:0];
                    state_next    = S_SDC1;
                end
                else
                begin
                    state_next = S_SDC2;
                end
            end
            S_SDC1:
            begin
                // Right child wins only when strictly larger
                if (cmp_gt)
                begin
                    best_id_next  = rd_id;
                    best_key_next = rd_key;
                    child_next    = right_idx[SW-1:0];
                end
                state_next = S_SDC2;
            end
            S_SDC2:
            begin
                if (cmp_gt)
                begin
                    slot_req.en    = 1'b1;
                    slot_req.we    = 1'b1;
                    slot_req.addr  = hole_reg;
                    slot_req.wdata = {best_id_reg, best_key_reg};
                    pos_req.en     = 1'b1;
                    pos_req.we     = 1'b1;
                    pos_req.addr   = best_id_reg;
                    pos_req.wdata  = {1'b1, hole_reg};
                    hole_next      = child_reg;
                    state_next     = S_SDT;
                end
                else
                begin
                    state_next = S_SDE;
                end
            end
            S_SDE:
            begin
                slot_req.en    = 1'b1;
                slot_req.we    = 1'b1;
                slot_req.addr  = hole_reg;
                slot_req.wdata = {cur_id_reg, cur_key_reg};
                pos_req.en     = 1'b1;
                pos_req.we     = 1'b1;
                pos_req.addr   = cur_id_reg;
                pos_req.wdata  = {1'b1, hole_reg};
                case (phase_reg)
                    PH_BUILD:
                    begin
                        if (start_reg == '0)
                        begin
                            state_next = S_TOP;
                        end
                        else
                        begin
                            start_next = start_reg - SW'(1);
                            state_next = S_LOAD;
                        end
                    end
                    PH_DEL_DOWN:
                    begin
                        phase_next = PH_DEL_UP;
                        state_next = S_LOAD;
                    end
                    default:
                    begin
                        state_next = S_TOP;
                    end
                endcase
            end
            S_SUT:
            begin
                if (hole_reg == '0)
                begin
                    state_next = S_SUE;
                end
                else
                begin
                    child_next    = {1'b0, hole_m1[SW-1:1]};
                    slot_req.en   = 1'b1;
                    slot_req.addr = {1'b0, hole_m1[SW-1:1]};
                    state_next    = S_SUC;
                end
            end
            S_SUC:
            begin
                if (cmp_gt)
                begin
                    slot_req.en    = 1'b1;
                    slot_req.we    = 1'b1;
                    slot_req.addr  = hole_reg;
                    slot_req.wdata = slot_rdata;
                    pos_req.en     = 1'b1;
                    pos_req.we     = 1'b1;
                    pos_req.addr   = rd_id;
                    pos_req.wdata  = {1'b1, hole_reg};
                    hole_next      = child_reg;
                    state_next     = S_SUT;
                end
                else
                begin
                    state_next = S_SUE;
                end
            end
            S_SUE:
            begin
                slot_req.en    = 1'b1;
                slot_req.we    = 1'b1;
                slot_req.addr  = hole_reg;
                slot_req.wdata = {cur_id_reg, cur_key_reg};
                pos_req.en     = 1'b1;
                pos_req.we     = 1'b1;
                pos_req.addr   = cur_id_reg;
                pos_req.wdata  = {1'b1, hole_reg};
                state_next     = S_TOP;
            end
            S_TOP:
            begin
                slot_req.en   = 1'b1;
                slot_req.addr = '0;
                state_next    = S_TOPW;
            end
            S_TOPW:
            begin
                state_next = S_RES;
            end
            S_RES:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            phase_reg     <= PH_BUILD;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold working payload and the result beat
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        val_reg      <= val_next;
        err_reg      <= err_next;
        start_reg    <= start_next;
        hole_reg     <= hole_next;
        child_reg    <= child_next;
        cur_id_reg   <= cur_id_next;
        cur_key_reg  <= cur_key_next;
        best_id_reg  <= best_id_next;
        best_key_reg <= best_key_next;
        if (res_load)
        begin
            top_id_reg      <= (count_reg == '0) ? '0 : rd_id;
            top_key_reg     <= (count_reg == '0) ? '0 : imh_pkg::key_to_field(rd_key);
            entry_count_reg <= count_reg;
            is_empty_reg    <= (count_reg == '0);
            error_code_reg  <= err_reg;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign top_id      = top_id_reg;
    assign top_key     = top_key_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign error_code  = error_code_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(imh_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_count_in_chk: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg) == S_CHK)
        else $error("count moved outside the check step");

    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_LOOK)
        else $error("accepted beat did not start a lookup");

    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RES)
        else $error("result raised outside the result step");

endmodule
`default_nettype wire

// ===== rtl/indexed_max_heap.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_max_heap
// Indexed binary max-heap with append, bulk build, delete by id and decrease.
//
//   channel | signals                                   | dir
//   in      | in_valid/in_ready, mode, node_id, value   | input beat
//   out     | out_valid/out_ready, top_id, top_key,     | result beat
//           | entry_count, is_empty, error_code         |
//
// One beat at a time. Sift down reads one or two children per level,
// sift up one parent per level, both through the single-port slot
// memory. Build runs a sift down for each of count/2 parents. After
// reset a clearing pass over all 1024 ids empties the id map; no beat
// is taken until it ends. A stalled result holds the next beat in the
// sequencer until the output register frees.
// ----------------------------------------------------------------------------
module indexed_max_heap (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [imh_pkg::MODE_W-1:0]    mode,
    input  wire logic [imh_pkg::ID_W-1:0]      node_id,
    input  wire logic [imh_pkg::VALUE_W-1:0]   value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [imh_pkg::ID_W-1:0]           top_id,
    output logic [imh_pkg::TOPK_W-1:0]         top_key,
    output logic [imh_pkg::COUNT_W-1:0]        entry_count,
    output logic                               is_empty,
    output logic [imh_pkg::ERR_W-1:0]          error_code
);

    imh_pkg::slot_req_t           slot_req;
    imh_pkg::pos_req_t            pos_req;
    logic [imh_pkg::SLOT_DW-1:0]  slot_rdata;
    logic [imh_pkg::POS_DW-1:0]   pos_rdata;

    // Slot store
    imh_slot_ram u_slot_ram (
        .clk   (clk),
        .req   (slot_req),
        .rdata (slot_rdata)
    );

    // Id map
    imh_pos_ram u_pos_ram (
        .clk   (clk),
        .req   (pos_req),
        .rdata (pos_rdata)
    );

    // Sequencer
    imh_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .node_id     (node_id),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .top_id      (top_id),
        .top_key     (top_key),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .error_code  (error_code),
        .slot_req    (slot_req),
        .slot_rdata  (slot_rdata),
        .pos_req     (pos_req),
        .pos_rdata   (pos_rdata)
    );

endmodule
`default_nettype wire
